FILE: hw/rtl/bclpd_pkg.sv
package bclpd_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned MsWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  typedef logic [TimeWidth-1:0] time_ms_t;
  typedef logic [MsWidth-1:0] span_ms_t;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_ENABLE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_MS = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_LONG_PRESS_MS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic RST_DEBOUNCE_ENABLE = 1'b1;
  localparam span_ms_t RST_DEBOUNCE_MS = 16'd50;
  localparam span_ms_t RST_LONG_PRESS_MS = 16'd2000;

  // Reported event codes.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG = 2'd2
  } event_t;

endpackage

FILE: hw/rtl/button_click_long_press_detector.sv
// The event for an accepted request is registered and shows on the output in the cycle after acceptance.
// One request per cycle while the output is not stalled; the button state is read and updated in the same cycle.
// The output register is refilled while it is being taken, so there is no bubble.
// Reset (rst, synchronous, active high) clears the button state and the output valid,
// and loads the configuration defaults: debounce on, 50 ms window, 2000 ms long press.
module button_click_long_press_detector
  import bclpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  // Sample request channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     pin_level,
  input  logic [TimeWidth-1:0]     now_ms,
  // Event result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               event_res
);

  // Configuration registers.
  logic     debounce_enable;
  span_ms_t debounce_ms;
  span_ms_t long_press_ms;

  // Button state.
  logic     is_pressed;
  time_ms_t press_time;
  time_ms_t release_time;
  time_ms_t reported_time;

  // Next values of the state for the request in flight.
  logic     is_pressed_next;
  time_ms_t press_time_next;
  time_ms_t release_time_next;
  time_ms_t reported_time_next;
  event_t   event_next;

  // Output register.
  event_t   event_q;

  logic     accept;
  time_ms_t last_edge;
  time_ms_t since_edge;
  time_ms_t held_for;
  time_ms_t click_len;
  logic     refresh;
  logic     long_hit;
  logic     click_hit;
  time_ms_t cand_ts;
  event_t   cand_ev;

  // The output register can take a new event whenever it is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    // The last edge is the plain unsigned maximum of the press and release stamps;
    // it does not account for the timestamp wrapping around.
    last_edge = (press_time > release_time) ? press_time : release_time;
    since_edge = now_ms - last_edge;
    refresh = !debounce_enable || (since_edge > time_ms_t'(debounce_ms));

    // Refresh: record a press on a low pin while released, a release on a high pin
    // while pressed, unless the sample falls inside the debounce window.
    is_pressed_next = is_pressed;
    press_time_next = press_time;
    release_time_next = release_time;
    if (refresh) begin
      if (!is_pressed && !pin_level) begin
        is_pressed_next = 1'b1;
        press_time_next = now_ms;
      end else if (is_pressed && pin_level) begin
        is_pressed_next = 1'b0;
        release_time_next = now_ms;
      end
    end

    // Read: a long press is a hold past the threshold; a click is a completed
    // press shorter than it. A click takes precedence when both could apply.
    held_for = now_ms - press_time_next;
    click_len = release_time_next - press_time_next;
    long_hit = is_pressed_next && (held_for > time_ms_t'(long_press_ms));
    click_hit = !is_pressed_next && (release_time_next > press_time_next)
                && (click_len < time_ms_t'(long_press_ms));

    cand_ev = EV_NONE;
    cand_ts = '0;
    if (click_hit) begin
      cand_ev = EV_CLICK;
      cand_ts = release_time_next;
    end else if (long_hit) begin
      cand_ev = EV_LONG;
      cand_ts = press_time_next;
    end

    // Each event is reported once: the stamp of the last report identifies it.
    // With no edge seen yet, nothing is reported and the report stamp is kept.
    reported_time_next = reported_time;
    event_next = EV_NONE;
    if ((press_time_next != '0) || (release_time_next != '0)) begin
      if (reported_time != cand_ts) begin
        reported_time_next = cand_ts;
        event_next = cand_ev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_enable <= RST_DEBOUNCE_ENABLE;
      debounce_ms <= RST_DEBOUNCE_MS;
      long_press_ms <= RST_LONG_PRESS_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_ENABLE: debounce_enable <= cfg_data[0];
        CFG_DEBOUNCE_MS: debounce_ms <= cfg_data;
        CFG_LONG_PRESS_MS: long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed <= 1'b0;
      press_time <= '0;
      release_time <= '0;
      reported_time <= '0;
    end else if (accept) begin
      is_pressed <= is_pressed_next;
      press_time <= press_time_next;
      release_time <= release_time_next;
      reported_time <= reported_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_q <= event_next;
    end
  end

  assign event_res = event_q;

endmodule

FILE: hw/rtl/bclpd_checker.sv
module bclpd_checker
  import bclpd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           event_res
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("result changed while stalled");

  // A full, stalled output register blocks new requests.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while output is stalled");

  // Every accepted request produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Only the three defined event codes are ever delivered.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == EV_NONE) || (event_res == EV_CLICK)
                  || (event_res == EV_LONG))
    else $error("undefined event code");

endmodule

bind button_click_long_press_detector bclpd_checker u_bclpd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .event_res(event_res)
);

FILE: dv/tb_button_click_long_press_detector.sv
module tb_button_click_long_press_detector
  import bclpd_pkg::*;
;

  // The longest wait either side draws before offering or taking a request.
  localparam int unsigned MaxGap = 18;
  // How long the event side refuses results during a long stall.
  localparam int unsigned LongStallCycles = 80;
  // Each of the two long stalls starts once this many more samples have been accepted.
  localparam int unsigned LongStallEvery = 600;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // The block answers in the cycle after it accepts a request, so this settling time is plenty.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 210;

  // Scoreboard: a copy of the detector's button state and configuration that predicts
  // the event for each accepted sample, plus the queue of events still owed by the block.
  class button_event_scoreboard;
    logic     dbc_on;
    span_ms_t dbc_window;
    span_ms_t hold_limit;
    logic     btn_down;
    time_ms_t press_ms;
    time_ms_t release_ms;
    time_ms_t reported_ms;
    event_t   owed_events[$];
    int unsigned failures;

    function new();
      dbc_on = RST_DEBOUNCE_ENABLE;
      dbc_window = RST_DEBOUNCE_MS;
      hold_limit = RST_LONG_PRESS_MS;
      btn_down = 1'b0;
      press_ms = '0;
      release_ms = '0;
      reported_ms = '0;
      failures = 0;
    endfunction

    function void set_config(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_DEBOUNCE_ENABLE: dbc_on = data[0];
        CFG_DEBOUNCE_MS:     dbc_window = data;
        CFG_LONG_PRESS_MS:   hold_limit = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_events.size();
    endfunction

    // Runs the edge-recording step and then the event decision for one sample.
    function void note_sample(logic level, time_ms_t stamp);
      time_ms_t last_edge;
      time_ms_t since_edge;
      time_ms_t held_for;
      time_ms_t click_len;
      time_ms_t cand_ms;
      event_t   ev;
      // The newest edge is the plain unsigned maximum, not a wrap-aware one.
      last_edge = (press_ms > release_ms) ? press_ms : release_ms;
      since_edge = stamp - last_edge;
      if (!dbc_on || since_edge > time_ms_t'(dbc_window)) begin
        if (!btn_down && level == 1'b0) begin
          btn_down = 1'b1;
          press_ms = stamp;
        end else if (btn_down && level == 1'b1) begin
          btn_down = 1'b0;
          release_ms = stamp;
        end
      end
      // Until some edge has a nonzero timestamp nothing is reported at all.
      if (press_ms == '0 && release_ms == '0) begin
        owed_events.push_back(EV_NONE);
        return;
      end
      ev = EV_NONE;
      cand_ms = '0;
      held_for = stamp - press_ms;
      click_len = release_ms - press_ms;
      if (btn_down && held_for > time_ms_t'(hold_limit)) begin
        ev = EV_LONG;
        cand_ms = press_ms;
      end
      if (!btn_down && release_ms > press_ms && click_len < time_ms_t'(hold_limit)) begin
        ev = EV_CLICK;
        cand_ms = release_ms;
      end
      if (reported_ms == cand_ms) begin
        owed_events.push_back(EV_NONE);
      end else begin
        reported_ms = cand_ms;
        owed_events.push_back(ev);
      end
    endfunction

    function void check_event(logic [1:0] got);
      event_t want;
      if (owed_events.size() == 0) begin
        failures++;
        $display("%0t: event %0d with no sample waiting for it", $time, got);
        return;
      end
      want = owed_events.pop_front();
      if (got !== want) begin
        failures++;
        $display("%0t: event_res mismatch, expected %0d (%s), got %0d",
                 $time, want, want.name(), got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic pin_level;
  logic [TimeWidth-1:0] now_ms;
  logic out_valid;
  logic out_ready;
  logic [1:0] event_res;

  button_event_scoreboard sb;

  // Current settings as the stimulus sees them, used to shape press timing.
  int unsigned cur_dbc_ms;
  int unsigned cur_hold_ms;
  // Running millisecond clock for well-formed press sequences.
  time_ms_t cur_ms;
  int unsigned samples_taken;
  int unsigned idle_cycles;
  bit send_burst;
  bit take_burst;

  // Settings for the random phases. They include both ends of every register,
  // a long-press time of zero, and debounce switched off.
  bit [15:0] phase_dbc_on[NumPhases] = '{16'd1, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1};
  bit [15:0] phase_dbc_ms[NumPhases] =
    '{16'd50, 16'd0, 16'd65535, 16'd5, 16'd10, 16'd0, 16'd20, 16'd3};
  bit [15:0] phase_hold_ms[NumPhases] =
    '{16'd2000, 16'd1, 16'd65535, 16'd40, 16'd300, 16'd0, 16'd65535, 16'd25};

  button_click_long_press_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pin_level (pin_level),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res)
  );

  always #5 clk = ~clk;

  // Each side either idles a random number of cycles per request or, in burst
  // mode, not at all. Burst mode flips now and then so both patterns occur.
  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Offers one sample request and returns at the edge where it is accepted.
  // The valid line is left high so that a back-to-back request needs no
  // second assignment in the same step; the next call or a drain lowers it.
  task automatic send_sample(logic level, time_ms_t stamp);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) begin
      send_burst = !send_burst;
    end
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_level <= level;
    now_ms <= stamp;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(level, stamp);
    samples_taken++;
  endtask

  // Stops offering requests and waits until every owed event has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic write_cfg(logic dbc_on, span_ms_t dbc_ms, span_ms_t hold_ms);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_ENABLE;
    cfg_data <= CfgDataWidth'(dbc_on);
    @(posedge clk);
    sb.set_config(CFG_DEBOUNCE_ENABLE, CfgDataWidth'(dbc_on));
    cfg_index <= CFG_DEBOUNCE_MS;
    cfg_data <= dbc_ms;
    @(posedge clk);
    sb.set_config(CFG_DEBOUNCE_MS, dbc_ms);
    cfg_index <= CFG_LONG_PRESS_MS;
    cfg_data <= hold_ms;
    @(posedge clk);
    sb.set_config(CFG_LONG_PRESS_MS, hold_ms);
    cfg_we <= 1'b0;
    cur_dbc_ms = 32'(dbc_ms);
    cur_hold_ms = 32'(hold_ms);
  endtask

  // A realistic press: wait out the debounce window, press, a few held samples
  // with an occasional bounce high, release after a hold that lands on either
  // side of the long-press time, then a few released samples with bounces.
  task automatic press_sequence();
    time_ms_t press_at;
    int unsigned hold;
    int unsigned n;
    int unsigned tail;
    cur_ms += cur_dbc_ms + 1 + $urandom_range(0, 4);
    press_at = cur_ms;
    send_sample(1'b0, press_at);
    if ($urandom_range(0, 1) == 1) begin
      hold = $urandom_range(0, cur_hold_ms);
    end else begin
      hold = cur_hold_ms + $urandom_range(0, cur_hold_ms + 2);
    end
    n = $urandom_range(0, 4);
    for (int i = 1; i <= n; i++) begin
      send_sample($urandom_range(0, 7) == 0, press_at + time_ms_t'(hold * i / (n + 1)));
    end
    cur_ms = press_at + hold;
    send_sample(1'b1, cur_ms);
    tail = $urandom_range(0, 3);
    repeat (tail) begin
      cur_ms += $urandom_range(0, cur_hold_ms / 2 + cur_dbc_ms);
      send_sample($urandom_range(0, 5) != 0, cur_ms);
    end
  endtask

  // Stray samples: arbitrary timestamps, a jump to just before the wrap,
  // time running backwards, short steps with random level, and a zero stamp.
  task automatic stray_sample();
    logic level;
    level = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: begin
        cur_ms = $urandom;
        send_sample(level, cur_ms);
      end
      1: begin
        cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * cur_hold_ms + cur_dbc_ms);
        send_sample(level, cur_ms);
      end
      2: send_sample(level, cur_ms - $urandom_range(0, cur_dbc_ms + cur_hold_ms));
      3: begin
        cur_ms += $urandom_range(0, 2 * cur_dbc_ms + 1);
        send_sample(level, cur_ms);
      end
      default: send_sample(level, '0);
    endcase
  endtask

  // Event side: takes results with its own random idling and checks each one.
  // Twice during the run it refuses results for a long stretch while samples
  // keep coming, so the output register fills and the block holds off requests.
  initial begin
    int unsigned gap;
    int unsigned stalls_done;
    stalls_done = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (stalls_done < 2 && samples_taken >= (stalls_done + 1) * LongStallEvery) begin
        out_ready <= 1'b0;
        repeat (LongStallCycles) @(posedge clk);
        stalls_done++;
      end
      if ($urandom_range(0, 39) == 0) begin
        take_burst = !take_burst;
      end
      gap = draw_gap(take_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_event(event_res);
    end
  end

  // A hung block shows up as a long run of cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_start;
    sb = new();
    samples_taken = 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    cur_dbc_ms = 32'(RST_DEBOUNCE_MS);
    cur_hold_ms = 32'(RST_LONG_PRESS_MS);
    cur_ms = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEBOUNCE_ENABLE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    pin_level <= 1'b1;
    now_ms <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset settings (debounce on, 50 ms, 2000 ms).
    // Released at time zero: no edge has been seen yet, so nothing is reported.
    send_sample(1'b1, 32'h0000_0000);
    // A press at time zero sits inside the debounce window of the zero edge.
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b1, 32'hFFFF_FFFF);
    // Press at 100; held exactly the long-press time is not yet a long press.
    send_sample(1'b0, 32'd100);
    send_sample(1'b0, 32'd2100);
    send_sample(1'b0, 32'd2101);
    // The same long press must not be reported twice.
    send_sample(1'b0, 32'd3000);
    // Releasing a long press leaves nothing pending, which clears the report.
    send_sample(1'b1, 32'd3040);
    // A press 40 ms after the release is a bounce; 51 ms later it counts.
    send_sample(1'b0, 32'd3080);
    send_sample(1'b0, 32'd3091);
    send_sample(1'b1, 32'd3500);
    send_sample(1'b1, 32'd3600);
    // A press just before the timestamp wraps, held across the wrap.
    send_sample(1'b0, 32'hFFFF_FF00);
    send_sample(1'b0, 32'h0000_0800);
    // The release now looks older than the press, so it can never be a click.
    send_sample(1'b1, 32'h0000_0900);
    send_sample(1'b0, 32'h0000_0940);
    drain();

    // Debounce off and a long-press time of zero: no click is possible and
    // a single millisecond of hold is already a long press.
    write_cfg(1'b0, 16'd0, 16'd0);
    send_sample(1'b1, 32'h0000_1000);
    send_sample(1'b0, 32'h0000_1000);
    send_sample(1'b0, 32'h0000_1001);
    send_sample(1'b1, 32'h0000_1001);
    send_sample(1'b0, 32'h0000_1001);
    // Widest debounce window with the longest hold time.
    drain();
    write_cfg(1'b1, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 32'h0001_1001);
    send_sample(1'b0, 32'h0001_1002);
    drain();

    // Random phases: mostly well-formed presses with random timing, the rest
    // stray samples. Each phase starts idle so the registers can be rewritten.
    for (int p = 0; p < NumPhases; p++) begin
      write_cfg(phase_dbc_on[p][0], phase_dbc_ms[p], phase_hold_ms[p]);
      if ($urandom_range(0, 2) == 0) begin
        cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * cur_hold_ms + cur_dbc_ms);
      end
      phase_start = samples_taken;
      while (samples_taken - phase_start < ItemsPerPhase) begin
        if ($urandom_range(0, 9) < 7) begin
          press_sequence();
        end else begin
          stray_sample();
        end
      end
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bclpd_pkg.sv
hw/rtl/button_click_long_press_detector.sv
hw/rtl/bclpd_checker.sv
dv/tb_button_click_long_press_detector.sv
